// ===== sv/cle_pkg.sv =====
// cle_pkg: shared constants, types and helper functions for the console line editor
// no dependencies; imported by cle_ring, cle_result and console_line_editor_core
package cle_pkg;

   // ring depth, a power of two; indices run free over twice the depth
   localparam int BUF_DEPTH = 128;
   localparam int SLOT_W    = $clog2(BUF_DEPTH);
   localparam int IDX_W     = SLOT_W + 1;

   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] CH_CTRL_U  = 8'h15;
   localparam logic [7:0] CH_CTRL_C  = 8'h03;
   localparam logic [7:0] CH_CTRL_D  = 8'h04;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_NODATA  = 8'hFF;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;

   localparam logic [1:0] BURST_LAST = 2'd3;

   typedef enum logic {
      OP_RECV = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_ECHO  = 3'd0,
      KIND_ERASE = 3'd1,
      KIND_READ  = 3'd2,
      KIND_EOF   = 3'd3,
      KIND_EMPTY = 3'd4
   } kind_type;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] erase_count;
      logic       last;
   } rsp_item_type;

   // erase runs are capped at 255 characters
   function automatic logic [7:0] sat8(input idx_type v);
      logic [IDX_W+7:0] wide;
      begin
         wide = {8'b0, v};
         if (wide > (IDX_W+8)'(255)) begin
            return 8'hFF;
         end
         return wide[7:0];
      end
   endfunction

   // interrupt echo sequence
   function automatic logic [7:0] burst_char(input logic [1:0] pos);
      logic [7:0] ch;
      begin
         case (pos)
            2'd0:    ch = CH_CARET;
            2'd1:    ch = CH_UPPER_C;
            2'd2:    ch = CH_LF;
            default: ch = CH_DOLLAR;
         endcase
         return ch;
      end
   endfunction

endpackage

// ===== sv/cle_ring.sv =====
// cle_ring: ring indices, line store and the per-item edit decision
// depends on cle_pkg
module cle_ring import cle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic         op,
   input  logic [7:0]   rx_byte,
   output logic         load,
   output rsp_item_type item
);

   idx_type    read_ff, read_in;
   idx_type    commit_ff, commit_in;
   idx_type    edit_ff, edit_in;
   idx_type    edit_next, dist_read, dist_next;
   logic [7:0] rd_data_ff;
   logic [7:0] line_mem [BUF_DEPTH];
   logic       wr_en;
   logic [7:0] wr_char;
   logic [7:0] stored;
   logic [7:0] erase_n;

   always_comb begin
      read_in   = read_ff;
      commit_in = commit_ff;
      edit_in   = edit_ff;
      load      = 1'b0;
      wr_en     = 1'b0;
      item      = '{kind: KIND_ECHO, data: 8'h00, erase_count: 8'h00, last: 1'b1};
      stored    = (rx_byte == CH_CR) ? CH_LF : rx_byte;
      wr_char   = stored;
      erase_n   = sat8(idx_type'(edit_ff - commit_ff));
      edit_next = idx_type'(edit_ff + idx_type'(1));
      dist_read = idx_type'(edit_ff - read_ff);
      dist_next = idx_type'(edit_next - read_ff);
      if (go) begin
         if (op == OP_READ) begin
            load = 1'b1;
            if (read_ff == commit_ff) begin
               item.kind = KIND_EMPTY;
            end else begin
               read_in = idx_type'(read_ff + idx_type'(1));
               if (rd_data_ff == CH_CTRL_D) begin
                  item.kind = KIND_EOF;
               end else begin
                  item.kind = KIND_READ;
                  item.data = rd_data_ff;
               end
            end
         end else begin
            case (rx_byte)
               CH_NODATA: begin
               end
               CH_DEL: begin
                  if (edit_ff != commit_ff) begin
                     edit_in          = idx_type'(edit_ff - idx_type'(1));
                     load             = 1'b1;
                     item.kind        = KIND_ERASE;
                     item.erase_count = 8'd1;
                  end
               end
               CH_CTRL_U: begin
                  // the uncommitted line never holds a newline, so the run is its length
                  if (erase_n != 8'd0) begin
                     edit_in          = idx_type'(edit_ff - idx_type'(erase_n));
                     load             = 1'b1;
                     item.kind        = KIND_ERASE;
                     item.erase_count = erase_n;
                  end
               end
               CH_CTRL_C: begin
                  read_in   = '0;
                  commit_in = '0;
                  edit_in   = '0;
                  load      = 1'b1;
                  item.data = burst_char(2'd0);
                  item.last = 1'b0;
               end
               default: begin
                  if (!dist_read[IDX_W-1]) begin
                     wr_en     = 1'b1;
                     edit_in   = edit_next;
                     load      = 1'b1;
                     item.data = stored;
                     if (stored == CH_LF || stored == CH_CTRL_D ||
                         dist_next == idx_type'(BUF_DEPTH)) begin
                        commit_in = edit_next;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff   <= '0;
         commit_ff <= '0;
         edit_ff   <= '0;
      end else begin
         read_ff   <= read_in;
         commit_ff <= commit_in;
         edit_ff   <= edit_in;
      end
   end

   // write-first read of the slot the read index will point at
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[edit_ff[SLOT_W-1:0]] <= wr_char;
      end
      if (wr_en && edit_ff[SLOT_W-1:0] == read_in[SLOT_W-1:0]) begin
         rd_data_ff <= wr_char;
      end else begin
         rd_data_ff <= line_mem[read_in[SLOT_W-1:0]];
      end
   end

endmodule

// ===== sv/cle_result.sv =====
// cle_result: result register, plays out the interrupt echo sequence
// depends on cle_pkg
module cle_result import cle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item,
   input  logic         rsp_stall,
   output logic         out_free,
   output logic         rsp_valid,
   output logic [2:0]   rsp_kind,
   output logic [7:0]   rsp_data,
   output logic [7:0]   rsp_erase_count,
   output logic         rsp_last
);

   logic         valid_ff;
   rsp_item_type item_ff;
   logic [1:0]   pos_ff, pos_in;
   logic         xfer;

   assign xfer     = valid_ff && !rsp_stall;
   assign out_free = !valid_ff || (xfer && item_ff.last);
   assign pos_in   = pos_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         item_ff  <= item;
         pos_ff   <= 2'd0;
      end else if (xfer) begin
         if (item_ff.last) begin
            valid_ff <= 1'b0;
         end else begin
            pos_ff       <= pos_in;
            item_ff.data <= burst_char(pos_in);
            item_ff.last <= (pos_in == BURST_LAST);
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = item_ff.kind;
   assign rsp_data        = item_ff.data;
   assign rsp_erase_count = item_ff.erase_count;
   assign rsp_last        = item_ff.last;

endmodule

// ===== sv/console_line_editor_core.sv =====
// console_line_editor_core: top level of the console line editor
// depends on cle_pkg, cle_ring and cle_result
//
// Takes received bytes and read requests and returns echo, erase, read and status results.
// One item is taken per clock while the input is not stalled; it passes through the input
// register, waiting there while the result register is busy, and its result is then loaded
// into the result register. Each item gives at most one result, except Ctrl-C, which holds
// the result register for four transfers (^, C, newline, $) and stalls the input meanwhile.
// A full line store drops bytes silently; the store needs no clearing after reset.
module console_line_editor_core import cle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic [7:0] rsp_erase_count,
   output logic       rsp_last
);

   logic         item_valid_ff, item_valid_in;
   logic         item_op_ff;
   logic [7:0]   item_byte_ff;
   logic         out_free;
   logic         go;
   logic         load;
   logic         req_xfer;
   rsp_item_type item;

   assign go        = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_xfer) begin
         item_valid_in = 1'b1;
      end else if (go) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_op_ff   <= req_opcode;
         item_byte_ff <= req_rx_byte;
      end
   end

   cle_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .op      (item_op_ff),
      .rx_byte (item_byte_ff),
      .load    (load),
      .item    (item)
   );

   cle_result u_result (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .item            (item),
      .rsp_stall       (rsp_stall),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_erase_count (rsp_erase_count),
      .rsp_last        (rsp_last)
   );

   a_erase_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERASE |-> rsp_erase_count != 8'd0)
      else $error("erase run with zero count");

   a_single_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ECHO |-> rsp_last)
      else $error("non-echo result not marked last");

   a_stall_holds_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && rsp_valid)
      else $error("input stalled with no pending work");

   a_burst_advances : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_kind == KIND_ECHO)
      else $error("echo sequence broken");

endmodule
